// File: sv/ssm_pkg.sv
package ssm_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPLIT_MODE = 2'd0,
        REG_INVERT     = 2'd1
    } t_cfg_reg;

    // Split behavior codes held in the split_mode register.
    typedef enum logic [2:0] {
        MODE_ISOLATED   = 3'd0,
        MODE_REMOVED    = 3'd1,
        MODE_MERGE_PREV = 3'd2,
        MODE_MERGE_NEXT = 3'd3,
        MODE_CONTIGUOUS = 3'd4
    } t_split_mode;

    // Handshake between the step queue and the result stage.
    typedef struct packed {
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic pop;
    } t_q_ctrl;

endpackage

// File: sv/split_segment_merger_top.sv
// Split segment merger. Segments of one pre-token are pushed in order through
// push/full; merged spans come out through empty/pop, oldest first. A new
// segment is accepted in every cycle in which full is low: the merge decision
// against the held span is combinational and is recorded in a step queue of
// QUEUE_DEPTH entries. The result side delivers one beat per cycle while pop
// is high; a segment that pushes out a held span and also ends its group
// yields two output beats, so a steady input of such segments is held back
// by the output, while all other patterns run at one segment per cycle as
// long as pop stays high. A result passes through the step queue and then
// the output register. Configuration writes (split_mode at index 0,
// invert_matches at index 1) are always ready and must only be issued while
// the block is idle.
module split_segment_merger_top
    import ssm_pkg::*;
#(
    parameter int POS_WIDTH   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [POS_WIDTH-1:0]  i_seg_start,
    input  logic [POS_WIDTH-1:0]  i_seg_end,
    input  logic                  i_seg_is_match,
    input  logic                  i_seg_last,
    output logic                  empty,
    input  logic                  pop,
    output logic [POS_WIDTH-1:0]  o_span_start,
    output logic [POS_WIDTH-1:0]  o_span_end,
    output logic                  o_span_present,
    output logic                  o_group_last
);

    // One queue record carries up to two results of one segment.
    localparam int REC_W = 4 * POS_WIDTH + 3;

    logic             accept;
    logic             rec_valid;
    logic [REC_W-1:0] rec;
    logic [REC_W-1:0] head;
    t_q_status        q_status;
    t_q_ctrl          q_ctrl;

    // The configuration registers have no side effects on reads, so writes
    // are taken in any cycle.
    assign o_cfg_ready = 1'b1;

    // A segment is taken whenever the step queue has room.
    assign accept = push && !full;

    ssm_front #(
        .POS_WIDTH (POS_WIDTH),
        .REC_W     (REC_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_seg_start    (i_seg_start),
        .i_seg_end      (i_seg_end),
        .i_seg_is_match (i_seg_is_match),
        .i_seg_last     (i_seg_last),
        .o_rec_valid    (rec_valid),
        .o_rec          (rec)
    );

    ssm_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (rec_valid),
        .i_wr_data (rec),
        .o_full    (full),
        .i_ctrl    (q_ctrl),
        .o_status  (q_status),
        .o_head    (head)
    );

    // The back end unrolls each record into one or two result beats.
    ssm_back #(
        .POS_WIDTH (POS_WIDTH),
        .REC_W     (REC_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_status       (q_status),
        .i_head         (head),
        .o_ctrl         (q_ctrl),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_span_start   (o_span_start),
        .o_span_end     (o_span_end),
        .o_span_present (o_span_present),
        .o_group_last   (o_group_last)
    );

endmodule

// File: sv/ssm_front.sv
module ssm_front
    import ssm_pkg::*;
#(
    parameter int POS_WIDTH = 16,
    parameter int REC_W     = 4 * POS_WIDTH + 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic [POS_WIDTH-1:0]  i_seg_start,
    input  logic [POS_WIDTH-1:0]  i_seg_end,
    input  logic                  i_seg_is_match,
    input  logic                  i_seg_last,
    output logic                  o_rec_valid,
    output logic [REC_W-1:0]      o_rec
);

    logic [2:0]           r_split_mode;
    logic                 r_invert;
    logic [POS_WIDTH-1:0] r_held_start;
    logic [POS_WIDTH-1:0] r_held_end;
    logic                 r_held_valid;
    logic                 r_prev_match;

    logic                 m;
    logic                 ignore;
    logic                 extend;
    logic                 opens;
    logic                 emit_held;
    logic [POS_WIDTH-1:0] n_held_start;
    logic [POS_WIDTH-1:0] n_held_end;
    logic                 n_held_valid;
    logic                 n_prev_match;
    logic [POS_WIDTH-1:0] fin_start;
    logic [POS_WIDTH-1:0] fin_end;

    // Classify the segment against the held span.
    always_comb begin
        m      = i_seg_is_match ^ r_invert;
        ignore = 1'b0;
        extend = 1'b0;
        unique case (r_split_mode)
            MODE_REMOVED:    ignore = m;
            MODE_MERGE_PREV: extend = m && !r_prev_match && r_held_valid;
            MODE_MERGE_NEXT: extend = !m && r_prev_match && r_held_valid;
            MODE_CONTIGUOUS: extend = r_held_valid && (m == r_prev_match);
            default:         extend = 1'b0;
        endcase
        // Empty or reversed segments never open a span.
        opens     = !ignore && !extend && (i_seg_start < i_seg_end);
        emit_held = opens && r_held_valid;
    end

    always_comb begin
        n_held_start = r_held_start;
        n_held_end   = r_held_end;
        n_held_valid = r_held_valid;
        if (!ignore && extend) begin
            n_held_end = i_seg_end;
        end else if (opens) begin
            n_held_start = i_seg_start;
            n_held_end   = i_seg_end;
            n_held_valid = 1'b1;
        end
        n_prev_match = m;
        fin_start    = n_held_valid ? n_held_start : '0;
        fin_end      = n_held_valid ? n_held_end : '0;
        if (i_seg_last) begin
            n_held_valid = 1'b0;
            n_prev_match = 1'b0;
        end
    end

    // Record layout: first slot (held span pushed out), second slot (group end).
    assign o_rec_valid = i_accept && (emit_held || i_seg_last);
    assign o_rec = {emit_held, r_held_start, r_held_end,
                    i_seg_last, fin_start, fin_end, r_held_valid || opens || extend};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_mode <= MODE_ISOLATED;
            r_invert     <= 1'b0;
            r_held_valid <= 1'b0;
            r_prev_match <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_SPLIT_MODE) begin
                    r_split_mode <= i_cfg_data[2:0];
                end else if (i_cfg_index == REG_INVERT) begin
                    r_invert <= i_cfg_data[0];
                end
            end
            if (i_accept) begin
                r_held_valid <= n_held_valid;
                r_prev_match <= n_prev_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held_start <= n_held_start;
            r_held_end   <= n_held_end;
        end
    end

endmodule

// File: sv/ssm_queue.sv
module ssm_queue
    import ssm_pkg::*;
#(
    parameter int WIDTH = 67,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  t_q_ctrl          i_ctrl,
    output t_q_status        o_status,
    output logic [WIDTH-1:0] o_head
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [ADDR_W-1:0] r_wr_ptr;
    logic [ADDR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_pop;

    assign o_full          = (r_count == CNT_W'(DEPTH));
    assign o_status.empty  = (r_count == '0);
    assign o_head          = r_mem[r_rd_ptr];
    assign do_pop          = i_ctrl.pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == ADDR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_wr) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// File: sv/ssm_back.sv
module ssm_back
    import ssm_pkg::*;
#(
    parameter int POS_WIDTH = 16,
    parameter int REC_W     = 4 * POS_WIDTH + 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_q_status            i_status,
    input  logic [REC_W-1:0]     i_head,
    output t_q_ctrl              o_ctrl,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [POS_WIDTH-1:0] o_span_start,
    output logic [POS_WIDTH-1:0] o_span_end,
    output logic                 o_span_present,
    output logic                 o_group_last
);

    logic                 h_s0_valid;
    logic [POS_WIDTH-1:0] h_s0_start;
    logic [POS_WIDTH-1:0] h_s0_end;
    logic                 h_s1_valid;
    logic [POS_WIDTH-1:0] h_s1_start;
    logic [POS_WIDTH-1:0] h_s1_end;
    logic                 h_s1_present;

    logic                 r_out_valid;
    logic                 r_phase;
    logic [POS_WIDTH-1:0] r_start;
    logic [POS_WIDTH-1:0] r_end;
    logic                 r_present;
    logic                 r_last;

    logic                 load;
    logic                 take;
    logic                 use_s0;
    logic                 n_phase;

    assign {h_s0_valid, h_s0_start, h_s0_end,
            h_s1_valid, h_s1_start, h_s1_end, h_s1_present} = i_head;

    // The output register refills whenever it is empty or being drained.
    always_comb begin
        load    = !r_out_valid || i_pop;
        take    = load && !i_status.empty;
        use_s0  = !r_phase && h_s0_valid;
        n_phase = r_phase;
        o_ctrl.pop = 1'b0;
        if (take) begin
            if (use_s0 && h_s1_valid) begin
                n_phase = 1'b1;
            end else begin
                n_phase    = 1'b0;
                o_ctrl.pop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= take;
            end
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (use_s0) begin
                r_start   <= h_s0_start;
                r_end     <= h_s0_end;
                r_present <= 1'b1;
                r_last    <= 1'b0;
            end else begin
                r_start   <= h_s1_start;
                r_end     <= h_s1_end;
                r_present <= h_s1_present;
                r_last    <= 1'b1;
            end
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_span_start   = r_start;
    assign o_span_end     = r_end;
    assign o_span_present = r_present;
    assign o_group_last   = r_last;

endmodule

// File: sv/ssm_checker.sv
module ssm_checker
    import ssm_pkg::*;
#(
    parameter int POS_WIDTH = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 empty,
    input logic                 pop,
    input logic [POS_WIDTH-1:0] o_span_start,
    input logic [POS_WIDTH-1:0] o_span_end,
    input logic                 o_span_present,
    input logic                 o_group_last
);

    // Nothing is offered right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result offered right after reset");

    // A result that does not close its group always carries a span.
    a_mid_has_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_group_last) |-> o_span_present)
        else $error("bare marker in the middle of a group");

    // A bare end marker closes its group and has zero positions.
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_span_present) |->
            (o_group_last && (o_span_start == '0) && (o_span_end == '0)))
        else $error("malformed bare end marker");

    // A waiting beat holds until it is taken.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(o_span_start) && $stable(o_span_end)
             && $stable(o_span_present) && $stable(o_group_last)))
        else $error("stalled beat changed");

endmodule

bind split_segment_merger_top ssm_checker #(
    .POS_WIDTH (POS_WIDTH)
) u_ssm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_span_start   (o_span_start),
    .o_span_end     (o_span_end),
    .o_span_present (o_span_present),
    .o_group_last   (o_group_last)
);

// File: bench/ssm_span_checker.sv
`timescale 1ns / 1ps

module ssm_span_checker
    import ssm_pkg::*;
#(
    parameter int POS_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    input  logic                  i_full,
    input  logic [POS_WIDTH-1:0]  i_seg_start,
    input  logic [POS_WIDTH-1:0]  i_seg_end,
    input  logic                  i_seg_is_match,
    input  logic                  i_seg_last,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  logic [POS_WIDTH-1:0]  i_span_start,
    input  logic [POS_WIDTH-1:0]  i_span_end,
    input  logic                  i_span_present,
    input  logic                  i_group_last,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [POS_WIDTH-1:0] start_pos;
        logic [POS_WIDTH-1:0] end_pos;
        logic                 present;
        logic                 grp_last;
    } t_span;

    t_span                span_queue[$];
    logic [2:0]           mode_q       = MODE_ISOLATED;
    logic                 invert_q     = 1'b0;
    logic [POS_WIDTH-1:0] held_start_q = '0;
    logic [POS_WIDTH-1:0] held_end_q   = '0;
    logic                 held_q       = 1'b0;
    logic                 prev_match_q = 1'b0;
    int                   fails        = 0;

    // One segment through the merge rules; appends the spans it releases.
    task automatic merge_segment(input logic [POS_WIDTH-1:0] seg_s,
                                 input logic [POS_WIDTH-1:0] seg_e,
                                 input logic seg_match, input logic seg_last);
        logic m;
        logic skip;
        logic grow;
        m    = seg_match ^ invert_q;
        skip = 1'b0;
        grow = 1'b0;
        case (mode_q)
            MODE_REMOVED:    skip = m;
            MODE_MERGE_PREV: grow = m && !prev_match_q && held_q;
            MODE_MERGE_NEXT: grow = !m && prev_match_q && held_q;
            MODE_CONTIGUOUS: grow = held_q && (m == prev_match_q);
            default:         ;
        endcase
        if (!skip) begin
            if (grow) begin
                held_end_q = seg_e;
            end else if (seg_s < seg_e) begin
                if (held_q)
                    span_queue.insert(span_queue.size(),
                                      t_span'{held_start_q, held_end_q, 1'b1, 1'b0});
                held_start_q = seg_s;
                held_end_q   = seg_e;
                held_q       = 1'b1;
            end
        end
        prev_match_q = m;
        if (seg_last) begin
            if (held_q)
                span_queue.insert(span_queue.size(),
                                  t_span'{held_start_q, held_end_q, 1'b1, 1'b1});
            else
                span_queue.insert(span_queue.size(), t_span'{'0, '0, 1'b0, 1'b1});
            held_q       = 1'b0;
            held_start_q = '0;
            held_end_q   = '0;
            prev_match_q = 1'b0;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, name, exp_val, act_val);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_span want;
        if (!i_rst_n) begin
            span_queue.delete();
            mode_q       = MODE_ISOLATED;
            invert_q     = 1'b0;
            held_start_q = '0;
            held_end_q   = '0;
            held_q       = 1'b0;
            prev_match_q = 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SPLIT_MODE: mode_q   = i_cfg_data[2:0];
                    REG_INVERT:     invert_q = i_cfg_data[0];
                    default:        ;
                endcase
            end
            if (i_push && !i_full)
                merge_segment(i_seg_start, i_seg_end, i_seg_is_match, i_seg_last);
            if (i_pop && !i_empty) begin
                if (span_queue.size() == 0) begin
                    $display("%0t: span beat with nothing expected, start %0d end %0d",
                             $time, i_span_start, i_span_end);
                    fails++;
                end else begin
                    want = span_queue.pop_front();
                    compare_field("span_start", 32'(want.start_pos), 32'(i_span_start));
                    compare_field("span_end", 32'(want.end_pos), 32'(i_span_end));
                    compare_field("span_present", 32'(want.present),
                                  32'(i_span_present));
                    compare_field("group_last", 32'(want.grp_last), 32'(i_group_last));
                end
            end
        end
        o_pending    <= span_queue.size();
        o_fail_count <= fails;
    end

endmodule

// File: bench/tb_split_segment_merger_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the split segment merger. The checker beside the
// block watches every beat on the three channels, keeps its own copy of the
// merge state and compares each span beat against its store of expected spans.
// This module only drives segments, configuration and the pop pattern.
module tb_split_segment_merger_top;
    import ssm_pkg::*;

    localparam int POS_WIDTH       = 16;
    localparam int RANDOM_SEGMENTS = 1000;
    localparam int PHASE_COUNT     = 16;
    // A result passes the step queue and then the output register; the wait
    // covers a segment still undecided when the last expected span arrived.
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 10;
    // Longest legitimate quiet stretch is a full receiver stall regime plus
    // a sender gap, so this is many times the slowest correct behavior.
    localparam int IDLE_LIMIT      = 5000;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = REG_SPLIT_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  push           = 1'b0;
    logic [POS_WIDTH-1:0]  i_seg_start    = '0;
    logic [POS_WIDTH-1:0]  i_seg_end      = '0;
    logic                  i_seg_is_match = 1'b0;
    logic                  i_seg_last     = 1'b0;
    logic                  pop            = 1'b0;

    logic                  o_cfg_ready;
    logic                  full;
    logic                  empty;
    logic [POS_WIDTH-1:0]  o_span_start;
    logic [POS_WIDTH-1:0]  o_span_end;
    logic                  o_span_present;
    logic                  o_group_last;

    int fail_count;
    int pending_spans;
    int idle_cycles  = 0;
    int burst_left   = 0;
    bit push_held    = 1'b0;
    int regime       = 0;
    int regime_left  = 0;

    split_segment_merger_top #(
        .POS_WIDTH (POS_WIDTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_seg_start    (i_seg_start),
        .i_seg_end      (i_seg_end),
        .i_seg_is_match (i_seg_is_match),
        .i_seg_last     (i_seg_last),
        .empty          (empty),
        .pop            (pop),
        .o_span_start   (o_span_start),
        .o_span_end     (o_span_end),
        .o_span_present (o_span_present),
        .o_group_last   (o_group_last)
    );

    ssm_span_checker #(
        .POS_WIDTH (POS_WIDTH)
    ) u_span_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_push         (push),
        .i_full         (full),
        .i_seg_start    (i_seg_start),
        .i_seg_end      (i_seg_end),
        .i_seg_is_match (i_seg_is_match),
        .i_seg_last     (i_seg_last),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_span_start   (o_span_start),
        .i_span_end     (o_span_end),
        .i_span_present (o_span_present),
        .i_group_last   (o_group_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending_spans)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // The receiver runs in regimes of random length: always ready, mostly
    // ready, mostly stalled, or stalled for the whole regime. The always-ready
    // regime gives stretches where the output runs at full rate, which lets
    // the two-beat segments back up into full on their own.
    always @(posedge i_clk) begin
        if (regime_left == 0) begin
            regime      = $urandom_range(0, 3);
            regime_left = $urandom_range(8, 80);
        end else begin
            regime_left--;
        end
        case (regime)
            0:       pop <= 1'b1;
            1:       pop <= ($urandom_range(0, 3) != 0);
            2:       pop <= ($urandom_range(0, 3) == 0);
            default: pop <= 1'b0;
        endcase
    end

    // Watchdog: any beat on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("split_segment_merger_top regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one segment and returns at the edge where it is taken. Within a
    // burst push simply stays high into the next segment; at the end of a
    // burst it drops for a random gap.
    task automatic send_segment(input logic [POS_WIDTH-1:0] seg_s,
                                input logic [POS_WIDTH-1:0] seg_e,
                                input logic seg_match, input logic seg_last);
        push           <= 1'b1;
        i_seg_start    <= seg_s;
        i_seg_end      <= seg_e;
        i_seg_is_match <= seg_match;
        i_seg_last     <= seg_last;
        do @(posedge i_clk); while (full);
        if (burst_left > 0) begin
            burst_left--;
            push_held = 1'b1;
        end else begin
            push      <= 1'b0;
            push_held = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 10);
        end
    endtask

    // Holds the sender until every expected span has been popped, then lets
    // the block settle. The first edge is taken before looking at the count
    // so that a segment accepted at this very edge is already included.
    task automatic wait_drained();
        if (push_held) begin
            push      <= 1'b0;
            push_held = 1'b0;
        end
        do @(posedge i_clk); while (pending_spans != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers back to back with valid held high between beats.
    // The unused upper data bits are randomized; the block keeps only the
    // low bits of each register.
    task automatic apply_setting(input logic [2:0] mode, input logic invert);
        logic [CFG_DATA_W-1:0] noise;
        noise       = CFG_DATA_W'($urandom);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_SPLIT_MODE;
        i_cfg_data  <= {noise[CFG_DATA_W-1:3], mode};
        do @(posedge i_clk); while (!o_cfg_ready);
        noise       = CFG_DATA_W'($urandom);
        i_cfg_index <= REG_INVERT;
        i_cfg_data  <= {noise[CFG_DATA_W-1:1], invert};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Random traffic for one phase. Most of it is well-formed groups of
    // adjacent segments ending in a last mark, so that the held span really
    // gets extended; mixed in are empty and reversed segments, groups cut
    // short without a last mark, and fully random noise segments.
    task automatic run_groups(input int seg_count);
        int                   sent;
        int                   group_len;
        int                   pick;
        logic [POS_WIDTH-1:0] pos;
        logic [POS_WIDTH-1:0] seg_e;
        bit                   cut_short;
        sent = 0;
        while (sent < seg_count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_segment(POS_WIDTH'($urandom), POS_WIDTH'($urandom),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                group_len = $urandom_range(1, 8);
                pos       = POS_WIDTH'($urandom);
                cut_short = ($urandom_range(0, 19) == 0);
                for (int k = 0; k < group_len; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 7)
                        seg_e = pos;
                    else if (pick < 15)
                        seg_e = pos - POS_WIDTH'($urandom_range(1, 40));
                    else
                        seg_e = pos + POS_WIDTH'($urandom_range(1, 12));
                    send_segment(pos, seg_e, 1'($urandom_range(0, 1)),
                                 (k == group_len - 1) && !cut_short);
                    pos = seg_e;
                    sent++;
                end
            end
            // Now and then the sender stops until the output is fully drained.
            if ($urandom_range(0, 49) == 0)
                wait_drained();
        end
    endtask

    initial begin
        logic [2:0] phase_mode;
        logic       phase_invert;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Isolated mode first: a full-range span, an empty
        // segment at the top of the position range that must not release it,
        // a reversed final segment that flushes it, and a group end with
        // nothing held, which gives a bare end marker.
        apply_setting(MODE_ISOLATED, 1'b0);
        send_segment(16'd0, 16'hFFFF, 1'b0, 1'b0);
        send_segment(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        send_segment(16'hFFFF, 16'd0, 1'b0, 1'b1);
        send_segment(16'd7, 16'd7, 1'b0, 1'b1);
        send_segment(16'd0, 16'd1, 1'b1, 1'b0);
        send_segment(16'd1, 16'd2, 1'b0, 1'b0);
        send_segment(16'd2, 16'd3, 1'b1, 1'b1);
        wait_drained();

        // Contiguous: a run of matches joins, an empty segment still extends,
        // a gap starts a new span, and a reversed gap sets the end as given.
        apply_setting(MODE_CONTIGUOUS, 1'b0);
        send_segment(16'd100, 16'd110, 1'b1, 1'b0);
        send_segment(16'd110, 16'd120, 1'b1, 1'b0);
        send_segment(16'd120, 16'd120, 1'b1, 1'b0);
        send_segment(16'd120, 16'd130, 1'b0, 1'b0);
        send_segment(16'd130, 16'd125, 1'b0, 1'b1);
        wait_drained();

        // Merged with next under inversion: an unflagged gap acts as a match and
        // swallows the following segment.
        apply_setting(MODE_MERGE_NEXT, 1'b1);
        send_segment(16'd10, 16'd20, 1'b0, 1'b0);
        send_segment(16'd20, 16'd30, 1'b1, 1'b0);
        send_segment(16'd30, 16'd40, 1'b0, 1'b1);
        wait_drained();

        // Removed: matches vanish, and a group that ends on a dropped match
        // with nothing held produces only the end marker.
        apply_setting(MODE_REMOVED, 1'b0);
        send_segment(16'd0, 16'd5, 1'b1, 1'b0);
        send_segment(16'd5, 16'd9, 1'b0, 1'b1);
        send_segment(16'd9, 16'd12, 1'b1, 1'b1);
        wait_drained();

        // Merged with previous: a match joins the gap before it, but not a
        // second match in a row.
        apply_setting(MODE_MERGE_PREV, 1'b0);
        send_segment(16'd0, 16'd4, 1'b0, 1'b0);
        send_segment(16'd4, 16'd8, 1'b1, 1'b0);
        send_segment(16'd8, 16'd9, 1'b1, 1'b1);
        wait_drained();

        // Random part: every mode code, the undefined ones included, each
        // with and without inversion. The merge state carries over from one
        // phase to the next, just as it does in the block.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            phase_mode   = 3'(ph >> 1);
            phase_invert = ph[0];
            apply_setting(phase_mode, phase_invert);
            run_groups(RANDOM_SEGMENTS / PHASE_COUNT);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_spans == 0) begin
            $display("split_segment_merger_top regression: pass");
        end else begin
            $display("split_segment_merger_top regression: fail");
        end
        $finish;
    end

endmodule
